// File: src/cxsw_pkg.sv
`default_nettype none

package cxsw_pkg;

    localparam int NUM_ROWS = 12;
    localparam int NUM_COLS = 8;
    localparam int ROW_W    = 4;

    typedef logic [NUM_COLS-1:0] row_mask_t;
    typedef logic [ROW_W-1:0]    row_idx_t;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_RESET = 2'd2
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ROW  = 2'd1,
        ST_BAD_ADDR = 2'd2
    } status_code_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    typedef logic [7:0] rb_table_t [NUM_ROWS];

    localparam rb_table_t RB_TABLE = '{
        8'h34, 8'h3c, 8'h74, 8'h7c, 8'h35, 8'h3d,
        8'h75, 8'h7d, 8'h36, 8'h3e, 8'h76, 8'h7e
    };

endpackage

`default_nettype wire

// File: src/cxsw_ctrl.sv
`default_nettype none

module cxsw_ctrl
    import cxsw_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    output dp_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTRL_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd            = '0;
        case (state_reg)
            CTRL_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = CTRL_EXEC;
                end
            end
            CTRL_EXEC:
            begin
                // hold until the output word is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.execute    = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTH
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == CTRL_EXEC))
        else $error("accepted word did not enter execute");

    a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> rsp_valid)
        else $error("execute did not produce a result word");

    a_exec_waits_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CTRL_EXEC && !cmd.execute) |-> (rsp_valid && !rsp_ready))
        else $error("execute stalled without a blocked result");

    a_no_cmd_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute in one cycle");
`endif

endmodule

`default_nettype wire

// File: src/cxsw_dp.sv
`default_nettype none

module cxsw_dp
    import cxsw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_cmd_t    cmd,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] data_byte,
    input  wire logic       latch_now,
    output logic [7:0]      read_data,
    output logic [1:0]      status
);

    logic [1:0] type_reg;
    logic [7:0] data_reg;
    logic       latch_reg;
    logic [7:0] read_data_reg;
    logic [7:0] read_data_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;

    row_mask_t pending_reg [NUM_ROWS];
    row_mask_t pending_next [NUM_ROWS];
    row_mask_t active_reg [NUM_ROWS];
    row_mask_t active_next [NUM_ROWS];

    logic [3:0] row_code;
    logic       row_ok;
    row_idx_t   row_idx;
    row_mask_t  col_bit;
    logic       addr_hit;
    row_idx_t   addr_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg  <= req_type;
            data_reg  <= data_byte;
            latch_reg <= latch_now;
        end
        if (cmd.execute)
        begin
            read_data_reg <= read_data_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                pending_reg[r] <= '0;
                active_reg[r]  <= '0;
            end
        end
        else if (cmd.execute)
        begin
            pending_reg <= pending_next;
            active_reg  <= active_next;
        end
    end

    always_comb
    begin
        row_code = data_reg[6:3];
        row_ok   = 1'b0;
        row_idx  = '0;
        if (row_code inside {[4'd0:4'd5]})
        begin
            row_ok  = 1'b1;
            row_idx = row_code;
        end
        else if (row_code inside {[4'd8:4'd13]})
        begin
            row_ok  = 1'b1;
            row_idx = row_code - 4'd2;
        end
        col_bit = row_mask_t'(1) << data_reg[2:0];
    end

    always_comb
    begin
        addr_hit = 1'b0;
        addr_idx = '0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (RB_TABLE[r] == data_reg)
            begin
                addr_hit = 1'b1;
                addr_idx = row_idx_t'(r);
            end
        end
    end

    always_comb
    begin
        pending_next   = pending_reg;
        active_next    = active_reg;
        read_data_next = '0;
        status_next    = ST_OK;
        case (type_reg)
            REQ_WRITE:
            begin
                if (!row_ok)
                begin
                    status_next = ST_BAD_ROW;
                end
                else
                begin
                    for (int r = 0; r < NUM_ROWS; r++)
                    begin
                        if (row_idx == row_idx_t'(r))
                        begin
                            if (data_reg[7])
                            begin
                                pending_next[r] = pending_reg[r] | col_bit;
                            end
                            else
                            begin
                                pending_next[r] = pending_reg[r] & ~col_bit;
                            end
                        end
                    end
                    if (latch_reg)
                    begin
                        active_next = pending_next;
                    end
                end
            end
            REQ_READ:
            begin
                if (!addr_hit)
                begin
                    status_next = ST_BAD_ADDR;
                end
                else
                begin
                    read_data_next = active_reg[addr_idx];
                end
            end
            REQ_RESET:
            begin
                for (int r = 0; r < NUM_ROWS; r++)
                begin
                    pending_next[r] = '0;
                    active_next[r]  = '0;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign read_data = read_data_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// File: src/crosspoint_switch_matrix_regs.sv
// Channel   Handshake                Fields
// request   req_valid / req_ready    req_type, data_byte, latch_now
// response  rsp_valid / rsp_ready    read_data, status
//
// Each word is captured, then executed into the output register.
// The 12x8 pending and active switch arrays update in the execute cycle.
// A new request is taken while a finished response still waits.
// Execute stalls while the output register holds an untaken response.
// rst_n opens every switch and empties the response register.
`default_nettype none

module crosspoint_switch_matrix_regs
    import cxsw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] data_byte,
    input  wire logic       latch_now,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output logic [7:0]      read_data,
    output logic [1:0]      status
);

    dp_cmd_t cmd;

    cxsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    cxsw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_type  (req_type),
        .data_byte (data_byte),
        .latch_now (latch_now),
        .read_data (read_data),
        .status    (status)
    );

endmodule

`default_nettype wire
